FILE: rtl/ogd_pkg.sv
// ----------------------------------------------------------------------------
// ogd_pkg: shared types, codes and helpers of the gesture direction decoder
// Holds the gesture codes, the register map, the burst sum type and the
// saturating difference accumulator used by the sum stage.
// ----------------------------------------------------------------------------
`default_nettype none

package ogd_pkg;

    // Gesture codes on the result beat
    localparam logic [2:0] GEST_NONE  = 3'd0;
    localparam logic [2:0] GEST_UP    = 3'd1;
    localparam logic [2:0] GEST_DOWN  = 3'd2;
    localparam logic [2:0] GEST_LEFT  = 3'd3;
    localparam logic [2:0] GEST_RIGHT = 3'd4;

    // Register map (index = paddr[2])
    localparam logic REG_DIFF_THRESHOLD  = 1'b0;
    localparam logic REG_IDLE_TIMEOUT_MS = 1'b1;

    localparam logic [7:0]  DIFF_THRESHOLD_RST  = 8'd13;
    localparam logic [15:0] IDLE_TIMEOUT_MS_RST = 16'd300;

    localparam logic signed [13:0] SUM_MAX = 14'sh1FFF;
    localparam logic signed [13:0] SUM_MIN = 14'sh2000;
    localparam logic [7:0]         COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic signed [13:0] vertical;
        logic signed [13:0] horizontal;
    } t_sums;

    typedef struct packed {
        logic        valid;
        logic [31:0] now_ms;
        t_sums       sums;
    } t_eval;

    // Add a - b into sum when |a - b| exceeds thr; saturate to 14 bits.
    function automatic logic signed [13:0] accumulate(
        input logic signed [13:0] sum,
        input logic [7:0]         a,
        input logic [7:0]         b,
        input logic [7:0]         thr
    );
        logic signed [8:0]  d;
        logic [8:0]         mag;
        logic signed [14:0] s;
        logic signed [13:0] res;
        d   = $signed({1'b0, a}) - $signed({1'b0, b});
        mag = d[8] ? 9'(-d) : 9'(d);
        s   = {sum[13], sum} + {{6{d[8]}}, d};
        res = sum;
        if (mag > {1'b0, thr}) begin
            if (s > 15'sd8191) begin
                res = SUM_MAX;
            end else if (s < -15'sd8192) begin
                res = SUM_MIN;
            end else begin
                res = s[13:0];
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : 8'(c + 8'd1);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ogd_accum.sv
// ----------------------------------------------------------------------------
// ogd_accum: burst sum stage
// Holds the vertical and horizontal burst sums and presents the sums that
// include the current dataset. Clears both sums after a burst's last beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ogd_accum
    import ogd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic       i_burst_end,
    input  wire logic [7:0] i_up_level,
    input  wire logic [7:0] i_down_level,
    input  wire logic [7:0] i_left_level,
    input  wire logic [7:0] i_right_level,
    input  wire logic [7:0] i_diff_threshold,
    output t_sums           o_sums_next
);

    t_sums r_sums;
    t_sums n_sums;

    always_comb begin
        n_sums.vertical   = accumulate(r_sums.vertical, i_up_level, i_down_level,
                                       i_diff_threshold);
        n_sums.horizontal = accumulate(r_sums.horizontal, i_left_level, i_right_level,
                                       i_diff_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
        end else if (i_advance) begin
            r_sums <= i_burst_end ? '0 : n_sums;
        end
    end

    assign o_sums_next = n_sums;

endmodule

`default_nettype wire

FILE: rtl/ogd_decide.sv
// ----------------------------------------------------------------------------
// ogd_decide: direction counts and gesture decision
// Updates the four direction counts at a burst's end, decides the gesture,
// tracks the last motion time and clears the counts on gesture or idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ogd_decide
    import ogd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_eval            i_eval,
    input  wire logic [15:0] i_idle_timeout_ms,
    output logic [2:0]       o_gesture
);

    logic [7:0]  r_up_count, r_down_count, r_left_count, r_right_count;
    logic [7:0]  n_up_count, n_down_count, n_left_count, n_right_count;
    logic [31:0] r_last_motion;
    logic [31:0] n_last_motion;
    logic [31:0] idle_ms;
    logic        motion;
    logic        idle;
    logic [2:0]  gesture;

    always_comb begin
        n_up_count    = r_up_count;
        n_down_count  = r_down_count;
        n_left_count  = r_left_count;
        n_right_count = r_right_count;
        gesture       = GEST_NONE;

        if (i_eval.sums.vertical < 0) begin
            if (r_down_count != 8'd0) gesture = GEST_UP;
            else n_up_count = bump(r_up_count);
        end else if (i_eval.sums.vertical > 0) begin
            if (r_up_count != 8'd0) gesture = GEST_DOWN;
            else n_down_count = bump(r_down_count);
        end

        // left/right wins over up/down
        if (i_eval.sums.horizontal < 0) begin
            if (r_right_count != 8'd0) gesture = GEST_LEFT;
            else n_left_count = bump(r_left_count);
        end else if (i_eval.sums.horizontal > 0) begin
            if (r_left_count != 8'd0) gesture = GEST_RIGHT;
            else n_right_count = bump(r_right_count);
        end

        // a burst with motion restamps the last motion time and never reads as idle
        motion        = (i_eval.sums.vertical != 0) || (i_eval.sums.horizontal != 0);
        n_last_motion = motion ? i_eval.now_ms : r_last_motion;
        idle_ms       = i_eval.now_ms - r_last_motion;
        idle          = !motion && (idle_ms > {16'd0, i_idle_timeout_ms});

        if ((gesture != GEST_NONE) || idle) begin
            n_up_count    = '0;
            n_down_count  = '0;
            n_left_count  = '0;
            n_right_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_count    <= '0;
            r_down_count  <= '0;
            r_left_count  <= '0;
            r_right_count <= '0;
            r_last_motion <= '0;
        end else if (i_eval.valid) begin
            r_up_count    <= n_up_count;
            r_down_count  <= n_down_count;
            r_left_count  <= n_left_count;
            r_right_count <= n_right_count;
            r_last_motion <= n_last_motion;
        end
    end

    assign o_gesture = gesture;

endmodule

`default_nettype wire

FILE: rtl/optical_gesture_direction.sv
// Order: a dataset beat is evaluated from the input register; the result beat
//   of a burst's last dataset is loaded into the output register.
// Throughput: one dataset beat per cycle unless a burst end waits on a stalled
//   result; sum and decision are one combinational pass between the registers.
// Reset: synchronous, active low; clears sums, counts, last motion time and
//   beat valid flags, and loads diff_threshold 13, idle_timeout_ms 300.
// ----------------------------------------------------------------------------
// optical_gesture_direction: four-channel optical gesture direction decoder
// Sums thresholded up/down and left/right photodiode differences over a FIFO
// burst and decides a swipe direction at the burst's last dataset.
// ----------------------------------------------------------------------------
`default_nettype none

module optical_gesture_direction
    import ogd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // dataset channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_up_level,
    input  wire logic [7:0]  i_down_level,
    input  wire logic [7:0]  i_left_level,
    input  wire logic [7:0]  i_right_level,
    input  wire logic        i_burst_end,
    input  wire logic [31:0] i_now_ms,

    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_gesture,

    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Index comes from paddr[2]; the low address
    // bits are the byte offset and are ignored.
    // ------------------------------------------------------------------
    logic [7:0]  r_diff_threshold;
    logic [15:0] r_idle_timeout_ms;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_threshold  <= DIFF_THRESHOLD_RST;
            r_idle_timeout_ms <= IDLE_TIMEOUT_MS_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_DIFF_THRESHOLD:  r_diff_threshold  <= pwdata[7:0];
                REG_IDLE_TIMEOUT_MS: r_idle_timeout_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DIFF_THRESHOLD:  prdata = {24'd0, r_diff_threshold};
            REG_IDLE_TIMEOUT_MS: prdata = {16'd0, r_idle_timeout_ms};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register. Hold one dataset beat; it moves on as soon as its
    // result (if any) has a free slot in the output register, so a new
    // beat can land in the same cycle.
    // ------------------------------------------------------------------
    logic        r_in_valid;
    logic [7:0]  r_up_level, r_down_level, r_left_level, r_right_level;
    logic        r_burst_end;
    logic [31:0] r_now_ms;
    logic        out_free;
    logic        advance;
    logic        in_take;

    assign out_free   = !o_out_valid || i_out_ready;
    // a mid-burst beat makes no result and never waits on the output side
    assign advance    = r_in_valid && (!r_burst_end || out_free);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_up_level    <= i_up_level;
            r_down_level  <= i_down_level;
            r_left_level  <= i_left_level;
            r_right_level <= i_right_level;
            r_burst_end   <= i_burst_end;
            r_now_ms      <= i_now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Sum stage: present the burst sums including this dataset.
    // ------------------------------------------------------------------
    t_sums sums_next;

    ogd_accum u_accum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_burst_end      (r_burst_end),
        .i_up_level       (r_up_level),
        .i_down_level     (r_down_level),
        .i_left_level     (r_left_level),
        .i_right_level    (r_right_level),
        .i_diff_threshold (r_diff_threshold),
        .o_sums_next      (sums_next)
    );

    // ------------------------------------------------------------------
    // Decision stage: only a burst's last dataset evaluates.
    // ------------------------------------------------------------------
    t_eval      eval;
    logic [2:0] gesture;

    always_comb begin
        eval.valid  = advance && r_burst_end;
        eval.now_ms = r_now_ms;
        eval.sums   = sums_next;
    end

    ogd_decide u_decide (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_eval            (eval),
        .i_idle_timeout_ms (r_idle_timeout_ms),
        .o_gesture         (gesture)
    );

    // ------------------------------------------------------------------
    // Output register: hold the result beat until taken; load a fresh one
    // in the cycle the old one leaves.
    // ------------------------------------------------------------------
    logic       r_out_valid;
    logic [2:0] r_gesture;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eval.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval.valid) begin
            r_gesture <= gesture;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gesture   = r_gesture;

`ifndef ASSERT_OFF
    // a result beat only ever carries a defined gesture code
    a_gesture_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_gesture <= GEST_RIGHT))
        else $error("gesture code out of range");

    // an evaluated burst end always shows up as a result beat
    a_eval_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eval.valid |=> o_out_valid)
        else $error("burst end evaluated without a result beat");

    // a pending, stalled result blocks evaluation of the next burst end
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !eval.valid)
        else $error("stalled result overwritten");

    // a held burst-end beat keeps the input side closed
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_burst_end && !out_free) |-> !o_in_ready)
        else $error("input taken while burst end is held");
`endif

endmodule

`default_nettype wire
